>>> sv/fnnh_pkg.sv
`timescale 1ns / 1ps
// Package for the four-nearest-neighbor height block.
// Holds shared constants, register codes and the slot control struct; no dependencies.
package fnnh_pkg;

  localparam int unsigned NEIGHBORS_DEF  = 4;
  localparam int unsigned COORD_BITS_DEF = 24;

  localparam int unsigned FILL_BITS    = 3;
  localparam logic [FILL_BITS-1:0] COUNT_MAX = 3'd7;

  localparam int unsigned DIGIT_BITS   = 4;
  localparam int unsigned CFG_IDX_BITS = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_QUERY_X = 2'd0,
    REG_QUERY_Y = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic load;
    logic clear;
  } fnnh_ctrl_t;

endpackage

>>> sv/four_nearest_neighbor_height.sv
`timescale 1ns / 1ps
// Throughput: one point per cycle unless stalled; the slot chain updates once per consumed
// point, and a final point enters the radix-16 divider pipeline, which takes a new result
// every cycle unless the output stalls.
// Reset: asynchronous active low; slots empty, running sum zero, query at zero, pipeline empty.
// Top level of the four-nearest-neighbor height block; uses fnnh_pkg, fnnh_slot, fnnh_div_stage.
module four_nearest_neighbor_height #(
  parameter  int unsigned NEIGHBORS  = fnnh_pkg::NEIGHBORS_DEF,
  parameter  int unsigned COORD_BITS = fnnh_pkg::COORD_BITS_DEF,
  localparam int unsigned IN_W       = ((3 * COORD_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W      = ((COORD_BITS + fnnh_pkg::FILL_BITS + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fnnh_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [COORD_BITS-1:0]             cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [IN_W-1:0]                   s_axis_tdata,  // point_x, point_y, point_z
  input  logic                              s_axis_tlast,  // final_point
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [OUT_W-1:0]                  m_axis_tdata   // mean_height, filled_count
);
  import fnnh_pkg::*;

  localparam int unsigned DIST_BITS = 2 * COORD_BITS + 1;
  localparam int unsigned IDX_BITS  = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
  localparam int unsigned CNT_BITS  = $clog2(NEIGHBORS + 1);
  localparam int unsigned SUM_BITS  = COORD_BITS + $clog2(NEIGHBORS);
  localparam int unsigned NDIG      = (SUM_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int unsigned WORK_BITS = NDIG * DIGIT_BITS;
  localparam int unsigned REM_BITS  = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
  localparam logic [SUM_BITS-1:0] OFFSET = SUM_BITS'(NEIGHBORS) << (COORD_BITS - 1);

  // Query registers
  logic [COORD_BITS-1:0] qx_q, qy_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qx_q <= '0;
      qy_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_QUERY_X: qx_q <= cfg_data_i;
        REG_QUERY_Y: qy_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage 1: absolute coordinate differences
  logic [COORD_BITS-1:0] px, py, pz;
  logic signed [COORD_BITS:0] diff_x, diff_y;
  logic [COORD_BITS:0]   neg_x, neg_y;
  logic [COORD_BITS-1:0] dx_d, dy_d;
  logic                  v1_q, rdy1;
  logic [COORD_BITS-1:0] dx_q, dy_q, z1_q;
  logic                  last1_q;
  logic                  rdy2;

  assign px = s_axis_tdata[COORD_BITS-1:0];
  assign py = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
  assign pz = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];

  assign diff_x = $signed({px[COORD_BITS-1], px}) - $signed({qx_q[COORD_BITS-1], qx_q});
  assign diff_y = $signed({py[COORD_BITS-1], py}) - $signed({qy_q[COORD_BITS-1], qy_q});
  assign neg_x  = -diff_x;
  assign neg_y  = -diff_y;
  assign dx_d   = diff_x[COORD_BITS] ? neg_x[COORD_BITS-1:0] : diff_x[COORD_BITS-1:0];
  assign dy_d   = diff_y[COORD_BITS] ? neg_y[COORD_BITS-1:0] : diff_y[COORD_BITS-1:0];

  assign rdy1          = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && s_axis_tvalid) begin
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      z1_q    <= pz;
      last1_q <= s_axis_tlast;
    end
  end

  // Stage 2: squared horizontal distance
  logic [2*COORD_BITS-1:0] sq_x, sq_y;
  logic [DIST_BITS-1:0]    dist_d;
  logic                    v2_q;
  logic [DIST_BITS-1:0]    dist2_q;
  logic [COORD_BITS-1:0]   z2_q;
  logic                    last2_q;
  logic                    consume;

  assign sq_x   = dx_q * dx_q;
  assign sq_y   = dy_q * dy_q;
  assign dist_d = {1'b0, sq_x} + {1'b0, sq_y};

  assign rdy2 = !v2_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      dist2_q <= dist_d;
      z2_q    <= z1_q;
      last2_q <= last1_q;
    end
  end

  // Slot chain
  logic                  c_stay   [NEIGHBORS];
  logic                  c_filled [NEIGHBORS];
  logic [DIST_BITS-1:0]  c_dist   [NEIGHBORS];
  logic [IDX_BITS-1:0]   c_idx    [NEIGHBORS];
  logic [COORD_BITS-1:0] c_height [NEIGHBORS];
  logic                  full;
  logic                  insert;
  logic [IDX_BITS-1:0]   new_idx;
  logic [CNT_BITS-1:0]   count_q, count_d, count_upd, count_res;
  logic [SUM_BITS-1:0]   sum_q, sum_d, sum_upd, sum_res, evict_h;
  logic                  cap_ready;
  fnnh_ctrl_t            slot_ctrl;

  assign full    = c_filled[NEIGHBORS-1];
  assign new_idx = full ? c_idx[NEIGHBORS-1] : count_q[IDX_BITS-1:0];
  assign insert  = !full || (dist2_q <= c_dist[NEIGHBORS-1]);
  assign consume = v2_q && (!last2_q || cap_ready);

  assign slot_ctrl.load  = consume && insert;
  assign slot_ctrl.clear = consume && last2_q;

  for (genvar gi = 0; gi < NEIGHBORS; gi++) begin : g_slot
    logic                  prev_stay;
    logic                  prev_filled;
    logic [DIST_BITS-1:0]  prev_dist;
    logic [IDX_BITS-1:0]   prev_idx;
    logic [COORD_BITS-1:0] prev_height;

    if (gi == 0) begin : g_head
      assign prev_stay   = 1'b1;
      assign prev_filled = 1'b1;
      assign prev_dist   = dist2_q;
      assign prev_idx    = new_idx;
      assign prev_height = z2_q;
    end else begin : g_body
      assign prev_stay   = c_stay[gi-1];
      assign prev_filled = c_filled[gi-1];
      assign prev_dist   = c_dist[gi-1];
      assign prev_idx    = c_idx[gi-1];
      assign prev_height = c_height[gi-1];
    end

    fnnh_slot #(
      .DIST_BITS (DIST_BITS),
      .IDX_BITS  (IDX_BITS),
      .COORD_BITS(COORD_BITS)
    ) u_slot (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (slot_ctrl),
      .new_dist_i   (dist2_q),
      .new_idx_i    (new_idx),
      .new_height_i (z2_q),
      .prev_stay_i  (prev_stay),
      .prev_filled_i(prev_filled),
      .prev_dist_i  (prev_dist),
      .prev_idx_i   (prev_idx),
      .prev_height_i(prev_height),
      .stay_o       (c_stay[gi]),
      .filled_o     (c_filled[gi]),
      .dist_o       (c_dist[gi]),
      .idx_o        (c_idx[gi]),
      .height_o     (c_height[gi])
    );
  end

  // Running sum of kept heights and fill count
  assign evict_h   = full ? SUM_BITS'($signed(c_height[NEIGHBORS-1])) : '0;
  assign sum_upd   = sum_q + SUM_BITS'($signed(z2_q)) - evict_h;
  assign count_upd = full ? count_q : CNT_BITS'(count_q + 1'b1);
  assign sum_res   = insert ? sum_upd : sum_q;
  assign count_res = insert ? count_upd : count_q;

  always_comb begin
    sum_d   = sum_q;
    count_d = count_q;
    if (consume) begin
      if (last2_q) begin
        sum_d   = '0;
        count_d = '0;
      end else begin
        sum_d   = sum_res;
        count_d = count_res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
    end else begin
      sum_q   <= sum_d;
      count_q <= count_d;
    end
  end

  // Result capture: offset sum so the floor division works on an unsigned value
  logic [CNT_BITS+2:0]  cnt_ext;
  logic [FILL_BITS-1:0] fill_sat;
  logic                 cap_v_q;
  logic [WORK_BITS-1:0] cap_work_q;
  logic [FILL_BITS-1:0] cap_fill_q;

  assign cnt_ext  = (CNT_BITS + 3)'(count_res);
  assign fill_sat = (cnt_ext > (CNT_BITS + 3)'(COUNT_MAX)) ? COUNT_MAX : cnt_ext[FILL_BITS-1:0];

  logic                 st_v    [NDIG+1];
  logic [WORK_BITS-1:0] st_work [NDIG+1];
  logic [REM_BITS-1:0]  st_rem  [NDIG+1];
  logic [FILL_BITS-1:0] st_fill [NDIG+1];
  logic                 st_rdy  [NDIG+2];

  assign cap_ready = !cap_v_q || st_rdy[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_v_q <= 1'b0;
    end else if (cap_ready) begin
      cap_v_q <= consume && last2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && last2_q) begin
      cap_work_q <= WORK_BITS'(SUM_BITS'(sum_res + OFFSET));
      cap_fill_q <= fill_sat;
    end
  end

  assign st_v[0]         = cap_v_q;
  assign st_work[0]      = cap_work_q;
  assign st_rem[0]       = '0;
  assign st_fill[0]      = cap_fill_q;
  assign st_rdy[0]       = cap_ready;
  assign st_rdy[NDIG+1]  = m_axis_tready;

  for (genvar gd = 1; gd <= NDIG; gd++) begin : g_div
    fnnh_div_stage #(
      .NEIGHBORS(NEIGHBORS),
      .WORK_BITS(WORK_BITS),
      .REM_BITS (REM_BITS)
    ) u_div_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(st_v[gd-1]),
      .ready_o(st_rdy[gd]),
      .work_i (st_work[gd-1]),
      .rem_i  (st_rem[gd-1]),
      .fill_i (st_fill[gd-1]),
      .valid_o(st_v[gd]),
      .ready_i(st_rdy[gd+1]),
      .work_o (st_work[gd]),
      .rem_o  (st_rem[gd]),
      .fill_o (st_fill[gd])
    );
  end

  // Quotient carries the offset in its top bit
  logic [COORD_BITS-1:0] mean;

  assign mean = {~st_work[NDIG][COORD_BITS-1], st_work[NDIG][COORD_BITS-2:0]};

  assign m_axis_tvalid = st_v[NDIG];
  assign m_axis_tdata  = OUT_W'({st_fill[NDIG], mean});

endmodule

>>> sv/fnnh_slot.sv
`timescale 1ns / 1ps
// One neighbor slot of the sorted insertion chain.
// Depends on fnnh_pkg for the slot control struct.
module fnnh_slot #(
  parameter int unsigned DIST_BITS  = 49,
  parameter int unsigned IDX_BITS   = 2,
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  fnnh_pkg::fnnh_ctrl_t       ctrl_i,
  input  logic [DIST_BITS-1:0]       new_dist_i,
  input  logic [IDX_BITS-1:0]        new_idx_i,
  input  logic [COORD_BITS-1:0]      new_height_i,
  input  logic                       prev_stay_i,
  input  logic                       prev_filled_i,
  input  logic [DIST_BITS-1:0]       prev_dist_i,
  input  logic [IDX_BITS-1:0]        prev_idx_i,
  input  logic [COORD_BITS-1:0]      prev_height_i,
  output logic                       stay_o,
  output logic                       filled_o,
  output logic [DIST_BITS-1:0]       dist_o,
  output logic [IDX_BITS-1:0]        idx_o,
  output logic [COORD_BITS-1:0]      height_o
);
  import fnnh_pkg::*;

  logic                  filled_q, filled_d;
  logic [DIST_BITS-1:0]  dist_q, dist_d;
  logic [IDX_BITS-1:0]   idx_q, idx_d;
  logic [COORD_BITS-1:0] height_q, height_d;
  logic                  take_new;
  logic                  move;

  // Sorted by distance ascending, ties by slot index descending; the tail is the eviction victim.
  assign stay_o   = filled_q && ((dist_q < new_dist_i) ||
                                 ((dist_q == new_dist_i) && (idx_q > new_idx_i)));
  assign take_new = prev_stay_i && !stay_o;
  assign move     = ctrl_i.load && !stay_o;

  always_comb begin
    filled_d = filled_q;
    dist_d   = dist_q;
    idx_d    = idx_q;
    height_d = height_q;
    if (move) begin
      if (take_new) begin
        filled_d = 1'b1;
        dist_d   = new_dist_i;
        idx_d    = new_idx_i;
        height_d = new_height_i;
      end else begin
        filled_d = prev_filled_i;
        dist_d   = prev_dist_i;
        idx_d    = prev_idx_i;
        height_d = prev_height_i;
      end
    end
    if (ctrl_i.clear) begin
      filled_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= 1'b0;
    end else begin
      filled_q <= filled_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q   <= dist_d;
    idx_q    <= idx_d;
    height_q <= height_d;
  end

  assign filled_o = filled_q;
  assign dist_o   = dist_q;
  assign idx_o    = idx_q;
  assign height_o = height_q;

endmodule

>>> sv/fnnh_div_stage.sv
`timescale 1ns / 1ps
// One digit stage of the divide-by-NEIGHBORS pipeline (radix 16, table lookup).
// Depends on fnnh_pkg for digit and count widths.
module fnnh_div_stage #(
  parameter int unsigned NEIGHBORS = 4,
  parameter int unsigned WORK_BITS = 28,
  parameter int unsigned REM_BITS  = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic [WORK_BITS-1:0]           work_i,
  input  logic [REM_BITS-1:0]            rem_i,
  input  logic [fnnh_pkg::FILL_BITS-1:0] fill_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic [WORK_BITS-1:0]           work_o,
  output logic [REM_BITS-1:0]            rem_o,
  output logic [fnnh_pkg::FILL_BITS-1:0] fill_o
);
  import fnnh_pkg::*;

  localparam int unsigned TAB_BITS  = REM_BITS + DIGIT_BITS;
  localparam int unsigned TAB_DEPTH = 2 ** TAB_BITS;

  logic [DIGIT_BITS-1:0] tab_q [TAB_DEPTH];
  logic [REM_BITS-1:0]   tab_r [TAB_DEPTH];

  for (genvar gv = 0; gv < TAB_DEPTH; gv++) begin : g_tab
    localparam int unsigned QV = gv / NEIGHBORS;
    localparam int unsigned RV = gv % NEIGHBORS;
    assign tab_q[gv] = DIGIT_BITS'(QV);
    assign tab_r[gv] = REM_BITS'(RV);
  end

  logic                 valid_q;
  logic [WORK_BITS-1:0] work_q;
  logic [REM_BITS-1:0]  rem_q;
  logic [FILL_BITS-1:0] fill_q;
  logic [TAB_BITS-1:0]  tab_idx;

  // Remainder and next dividend digit index the table; quotient digit shifts in at the bottom.
  assign tab_idx = {rem_i, work_i[WORK_BITS-1 -: DIGIT_BITS]};
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      work_q <= {work_i[WORK_BITS-DIGIT_BITS-1:0], tab_q[tab_idx]};
      rem_q  <= tab_r[tab_idx];
      fill_q <= fill_i;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;
  assign rem_o   = rem_q;
  assign fill_o  = fill_q;

endmodule

>>> sv/fnnh_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the four-nearest-neighbor height block, bound to the top level.
// Depends on fnnh_pkg and four_nearest_neighbor_height.
module fnnh_checker #(
  parameter  int unsigned NEIGHBORS  = fnnh_pkg::NEIGHBORS_DEF,
  parameter  int unsigned COORD_BITS = fnnh_pkg::COORD_BITS_DEF,
  localparam int unsigned OUT_W      = ((COORD_BITS + fnnh_pkg::FILL_BITS + 7) / 8) * 8
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);
  import fnnh_pkg::*;

  localparam int unsigned USED_W = COORD_BITS + FILL_BITS;
  localparam logic [FILL_BITS-1:0] FILL_LIMIT =
    (NEIGHBORS > 7) ? COUNT_MAX : FILL_BITS'(NEIGHBORS);

  logic [FILL_BITS-1:0] fill;

  assign fill = m_axis_tdata[USED_W-1:COORD_BITS];

  a_no_item_in_reset: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result item shown during reset");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result item changed");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> fill <= FILL_LIMIT)
    else $error("filled_count above slot count");

  if (OUT_W > USED_W) begin : g_pad
    a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid |-> m_axis_tdata[OUT_W-1:USED_W] == '0)
      else $error("tdata padding not zero");
  end

endmodule

bind four_nearest_neighbor_height fnnh_checker #(
  .NEIGHBORS (NEIGHBORS),
  .COORD_BITS(COORD_BITS)
) u_fnnh_checker (.*);

>>> dv/four_nearest_neighbor_height_test.sv
`timescale 1ns / 1ps
// Testbench for four_nearest_neighbor_height: streams surfaces of points past several
// query settings and checks each mean height against a predictor. Depends on fnnh_pkg.
module four_nearest_neighbor_height_test;
  import fnnh_pkg::*;

  localparam int CW       = COORD_BITS_DEF;
  localparam int KEEP     = NEIGHBORS_DEF;
  localparam int IN_W     = ((3 * CW + 7) / 8) * 8;
  localparam int OUT_W    = ((CW + FILL_BITS + 7) / 8) * 8;
  localparam int DRAIN    = 20;
  localparam int LIMIT    = 300000;
  localparam int PHASES   = 8;
  localparam int PER_PHASE = 58;

  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = 2'd3;

  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t               mean;
    logic [FILL_BITS-1:0] count;
  } height_result_t;

  class height_board;
    int             errors;
    coord_t         qx, qy;
    longint         slot_dist[KEEP];
    coord_t         hgt[KEEP];
    bit             filled[KEEP];
    height_result_t pending_means[$];

    function new();
      errors = 0;
      qx = '0;
      qy = '0;
      clear_slots();
    endfunction

    function void clear_slots();
      for (int i = 0; i < KEEP; i++) begin
        slot_dist[i] = 0;
        hgt[i] = '0;
        filled[i] = 1'b0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CW-1:0] data);
      if (idx == REG_QUERY_X) qx = data;
      else if (idx == REG_QUERY_Y) qy = data;
    endfunction

    function void note_point(coord_t x, coord_t y, coord_t z, bit last);
      longint         dx, dy, d, sum, q;
      int             tgt, far;
      int unsigned    cnt;
      height_result_t r;
      dx = longint'(x) - longint'(qx);
      dy = longint'(y) - longint'(qy);
      d = dx * dx + dy * dy;
      tgt = -1;
      for (int i = 0; i < KEEP; i++) begin
        if (!filled[i]) begin
          tgt = i;
          break;
        end
      end
      if (tgt < 0) begin
        far = 0;
        for (int i = 1; i < KEEP; i++) begin
          if (slot_dist[i] > slot_dist[far]) far = i;
        end
        if (d <= slot_dist[far]) tgt = far;
      end
      if (tgt >= 0) begin
        slot_dist[tgt] = d;
        hgt[tgt] = z;
        filled[tgt] = 1'b1;
      end
      if (!last) return;
      sum = 0;
      cnt = 0;
      for (int i = 0; i < KEEP; i++) begin
        if (filled[i]) begin
          sum += longint'(hgt[i]);
          cnt++;
        end
      end
      // floor toward minus infinity
      q = sum / KEEP;
      if ((sum % KEEP) != 0 && sum < 0) q--;
      if (cnt > COUNT_MAX) cnt = COUNT_MAX;
      r.mean = q[CW-1:0];
      r.count = cnt[FILL_BITS-1:0];
      pending_means.push_back(r);
      clear_slots();
    endfunction

    function void check_result(logic [OUT_W-1:0] word);
      coord_t               got_mean;
      logic [FILL_BITS-1:0] got_count;
      height_result_t       want;
      got_mean = word[CW-1:0];
      got_count = word[CW +: FILL_BITS];
      if (pending_means.size() == 0) begin
        $display("%0t: unexpected result, mean_height %0d filled_count %0d",
                 $time, got_mean, got_count);
        errors++;
        return;
      end
      want = pending_means.pop_front();
      if (got_mean !== want.mean) begin
        $display("%0t: mean_height expected %0d got %0d", $time, want.mean, got_mean);
        errors++;
      end
      if (got_count !== want.count) begin
        $display("%0t: filled_count expected %0d got %0d", $time, want.count, got_count);
        errors++;
      end
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i;
  logic [CW-1:0]           cfg_data_i;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [IN_W-1:0]         s_axis_tdata;
  logic                    s_axis_tlast;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [OUT_W-1:0]        m_axis_tdata;

  height_board board;
  int          send_gap_pct;
  int          recv_stall_pct;
  int          cycles;
  int          sent;

  four_nearest_neighbor_height DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // leaves cfg_valid_i high; caller lowers it
  task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, logic [CW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic program_query(coord_t qx, coord_t qy);
    cfg_write(REG_QUERY_X, qx);
    cfg_write(REG_QUERY_Y, qy);
    cfg_write(REG_SPARE_A, CW'($urandom));
    cfg_write(REG_SPARE_B, CW'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_point(coord_t x, coord_t y, coord_t z, bit last);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IN_W'({z, y, x});
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_point(x, y, z, last);
    sent++;
    @(negedge clk_i);
  endtask

  function automatic coord_t pick_coord(coord_t q);
    int off;
    case ($urandom_range(0, 3))
      0: return coord_t'($urandom);
      1: begin
        off = int'($urandom_range(0, 6)) - 3;
        return coord_t'(q + off);
      end
      2: begin
        off = 2 * (int'($urandom_range(0, 2)) - 1);
        return coord_t'(q + off);
      end
      default: begin
        off = int'($urandom_range(0, 2000)) - 1000;
        return coord_t'(q + off);
      end
    endcase
  endfunction

  task automatic send_surface(int len);
    coord_t x, y, z;
    for (int i = 0; i < len; i++) begin
      x = pick_coord(board.qx);
      y = pick_coord(board.qy);
      z = $urandom_range(0, 1) ? coord_t'($urandom) : coord_t'(int'($urandom_range(0, 40)) - 20);
      send_point(x, y, z, i == len - 1);
    end
  endtask

  task automatic drain();
    while (board.pending_means.size() != 0) @(negedge clk_i);
    repeat (DRAIN) @(negedge clk_i);
  endtask

  initial begin
    coord_t qx, qy;
    int     goal;
    board = new();
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_QUERY_X;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    cycles = 0;
    sent = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin qx = '0;    qy = '0;    end
        1: begin qx = C_MIN; qy = C_MAX; end
        2: begin qx = C_MAX; qy = C_MIN; end
        3: begin qx = C_MAX; qy = C_MAX; end
        default: begin qx = coord_t'($urandom); qy = coord_t'($urandom); end
      endcase
      program_query(qx, qy);
      case (p % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 46; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 46; end
        default: begin send_gap_pct = 12; recv_stall_pct = 12; end
      endcase

      if (p == 0) begin
        // lone final point
        send_point(0, 0, C_MIN, 1'b1);
        // two slots filled, negative sum floors
        send_point(1, 1, -1, 1'b0);
        send_point(2, 2, -2, 1'b1);
        send_point(C_MIN, C_MAX, C_MAX, 1'b0);
        send_point(C_MAX, C_MIN, C_MAX, 1'b0);
        send_point(5, 5, C_MAX, 1'b0);
        send_point(-5, -5, C_MAX, 1'b1);
        // equal distances: replacement takes the first farthest slot
        send_point(3, 0, 10, 1'b0);
        send_point(0, 3, 20, 1'b0);
        send_point(-3, 0, 30, 1'b0);
        send_point(0, -3, 40, 1'b0);
        send_point(3, 0, 100, 1'b0);
        send_point(100, 100, 1, 1'b0);
        send_point(1, 0, 7, 1'b0);
        send_point(0, C_MIN, 5, 1'b0);
        send_point(0, 0, C_MIN, 1'b1);
        send_point(1, 1, C_MIN, 1'b0);
        send_point(2, 1, C_MIN, 1'b0);
        send_point(1, 2, C_MIN, 1'b0);
        send_point(2, 2, C_MIN, 1'b1);
      end else if (p == 1) begin
        // query at one corner, points at the opposite one, the query corner, the center and another corner
        send_point(C_MAX, C_MIN, 1, 1'b1);
        send_point(C_MAX, C_MIN, 3, 1'b0);
        send_point(C_MAX, C_MIN, -4, 1'b0);
        send_point(C_MIN, C_MAX, 9, 1'b0);
        send_point(0, 0, 1, 1'b0);
        send_point(C_MAX, C_MAX, 2, 1'b1);
      end

      goal = sent + PER_PHASE;
      while (sent < goal) begin
        send_surface(($urandom_range(0, 9) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 9));
      end
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
      drain();
    end

    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/fnnh_pkg.sv
sv/fnnh_slot.sv
sv/fnnh_div_stage.sv
sv/four_nearest_neighbor_height.sv
sv/fnnh_checker.sv
dv/four_nearest_neighbor_height_test.sv
